[design/lifo_stack_with_dump_top_macros.svh]
// assertion macros for the lifo stack with dump
`ifndef LIFO_STACK_WITH_DUMP_TOP_MACROS_SVH
`define LIFO_STACK_WITH_DUMP_TOP_MACROS_SVH

// same-cycle implication
`define LSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lifo stack check failed");

// next-cycle implication
`define LSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lifo stack check failed");

`endif

[design/lsd_pkg.sv]
// shared types and constants for the lifo stack with dump
package lsd_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int ACT_W     = 2;
   localparam int ST_W      = 2;

   localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;
   localparam logic [ACT_W-1:0] ACT_DUMP = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic            push;       // write value at fill count, count up
      logic            rd_top;     // read entry below fill count
      logic            dec;        // count down (pop)
      logic            dump_ld;    // load dump pointer with top, read it
      logic            dump_step;  // move dump pointer down, read it
      logic            out_ld;     // load result register
      logic            out_mem;    // result data from read port, else zero
      logic [ST_W-1:0] out_status;
      logic            out_last;
   } lsd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic slot_free;  // result register empty or draining this cycle
      logic ptr_zero;   // dump pointer at bottom entry
   } lsd_stat_type;

endpackage

[design/lsd_ctrl.sv]
// controller state machine for the lifo stack with dump
module lsd_ctrl
   import lsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic [ACT_W-1:0] req_action,
   output logic             req_tready,
   input  lsd_stat_type     stat,
   output lsd_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = stat.slot_free;
            if (req_tvalid && stat.slot_free) begin
               case (req_action)
                  ACT_PUSH: begin
                     cmd.out_ld     = 1'b1;
                     cmd.out_last   = 1'b1;
                     cmd.out_status = stat.full ? ST_FULL : ST_OK;
                     cmd.push       = !stat.full;
                  end
                  ACT_POP, ACT_PEEK: begin
                     if (stat.empty) begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.rd_top = 1'b1;
                        cmd.dec    = (req_action == ACT_POP);
                        state_in   = S_RD;
                     end
                  end
                  default: begin
                     if (stat.empty) begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.dump_ld = 1'b1;
                        state_in    = S_DUMP;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            if (stat.slot_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_mem    = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_status = ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_DUMP: begin
            if (stat.slot_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_mem    = 1'b1;
               cmd.out_last   = stat.ptr_zero;
               cmd.out_status = ST_OK;
               if (stat.ptr_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.dump_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/lsd_datapath.sv]
// stack memory, fill count, dump pointer and result register
module lsd_datapath
   import lsd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] push_value,
   input  lsd_cmd_type              cmd,
   output lsd_stat_type             stat,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic        [ST_W-1:0]   rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            top_idx;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic [AW-1:0]            rd_addr;
   logic                     rd_en;
   logic                     valid_ff, valid_in;
   logic [ST_W-1:0]          status_ff;
   logic signed [DATA_W-1:0] data_ff;
   logic                     last_ff;

   assign top_idx = count_ff - CW'(1);
   assign rd_en   = cmd.rd_top || cmd.dump_ld || cmd.dump_step;
   assign rd_addr = cmd.dump_step ? (ptr_ff - AW'(1)) : top_idx[AW-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = top_idx;
      end
      ptr_in = ptr_ff;
      if (cmd.dump_ld || cmd.dump_step) begin
         ptr_in = rd_addr;
      end
      valid_in = valid_ff && !rsp_tready;
      if (cmd.out_ld) begin
         valid_in = 1'b1;
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.slot_free = !valid_ff || rsp_tready;
   assign stat.ptr_zero  = (ptr_ff == '0);

   // single write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[count_ff[AW-1:0]] <= push_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.out_ld) begin
         status_ff <= cmd.out_status;
         data_ff   <= cmd.out_mem ? rdata_ff : '0;
         last_ff   <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_data   = data_ff;
   assign rsp_last   = last_ff;

endmodule

[design/lifo_stack_with_dump_top.sv]
// lifo stack of signed words with push, pop, peek and dump
// requests enter on the req_ stream: action and push value in req_tdata.
// every request gives one or more results on the rsp_ stream: status and
// data in rsp_tdata, rsp_tlast high on the final result of the request.
// push: result in the cycle after the request, next request the cycle after;
// pushes and empty-stack requests run one per cycle while the receiver keeps up.
// pop / peek: the top word is read from the single registered read port of
// the stack memory and then moved into the result register; no new request
// is taken until the word has been moved.
// dump: after a first read, one result per cycle while the receiver keeps up,
// from top to bottom; the stack is left unchanged.
// a full stack reports full on push and drops the value; pop, peek and dump
// on an empty stack give a single empty result.
// reset clears the fill count and the result valid flag; stack words hold
// garbage until pushed and are never read before that.
// when the receiver stalls, the result holds in the output register and
// a new request is taken only once that register drains.
`include "lifo_stack_with_dump_top_macros.svh"

module lifo_stack_with_dump_top
   import lsd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action [1:0], push_value [33:2], zero [39:34]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status [1:0], data [33:2], zero [39:34]
   output logic        rsp_tlast
);

   lsd_cmd_type              cmd;
   lsd_stat_type             stat;
   logic [ACT_W-1:0]         req_action;
   logic signed [DATA_W-1:0] req_push_value;
   logic [ST_W-1:0]          rsp_status;
   logic signed [DATA_W-1:0] rsp_data;

   // unpack request fields
   assign req_action     = req_tdata[ACT_W-1:0];
   assign req_push_value = req_tdata[ACT_W+DATA_W-1:ACT_W];

   // control: idle / read top / dump walk
   lsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_action),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // storage and result register
   lsd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_push_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_tlast)
   );

   // pack result fields, pad to whole bytes
   assign rsp_tdata = {6'd0, rsp_data, rsp_status};

   // no new request while a result is stuck in the output register
   `LSD_ASSERT_NOW(a_no_req_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // a request either loads a result or parks the controller in a read state
   `LSD_ASSERT_NEXT(a_req_progress, clock, reset, req_tvalid && req_tready, rsp_tvalid || !req_tready)
   // stack memory only written while there is room
   `LSD_ASSERT_NOW(a_push_has_room, clock, reset, cmd.push, !stat.full)

endmodule
